@@ src/debd_pkg.sv @@
// Package: shared types and constants for the dual eye blink detector.
`timescale 1ns / 1ps

package debd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 32;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [TIMEOUT_W-1:0] ARM_TIMEOUT_RESET  = 16'd500;
    localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RESET = 16'd800;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_TIMEOUT  = 1'b0,
        REG_RISE_TIMEOUT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] start_frame;
        logic [TIME_W-1:0]  start_time;
        logic               busy;
    } eye_result_t;

    typedef struct packed {
        eye_result_t left;
        eye_result_t right;
    } blink_item_t;

endpackage

@@ src/debd_if.sv @@
// Interfaces: frame input channel, blink result channel and configuration write channel.
`timescale 1ns / 1ps

interface debd_frame_if;
    import debd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [FRAME_W-1:0]  frame_number;
    logic        [TIME_W-1:0]   time_ms;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] left_low_threshold;
    logic signed [SAMPLE_W-1:0] left_high_threshold;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic signed [SAMPLE_W-1:0] right_low_threshold;
    logic signed [SAMPLE_W-1:0] right_high_threshold;

    modport source (
        output valid, frame_number, time_ms,
               left_sample, left_low_threshold, left_high_threshold,
               right_sample, right_low_threshold, right_high_threshold,
        input  ready
    );

    modport sink (
        input  valid, frame_number, time_ms,
               left_sample, left_low_threshold, left_high_threshold,
               right_sample, right_low_threshold, right_high_threshold,
        output ready
    );
endinterface

interface debd_blink_if;
    import debd_pkg::*;

    logic               valid;
    logic               ready;
    logic               left_blink_found;
    logic [FRAME_W-1:0] left_start_frame;
    logic [TIME_W-1:0]  left_start_time;
    logic               left_busy;
    logic               right_blink_found;
    logic [FRAME_W-1:0] right_start_frame;
    logic [TIME_W-1:0]  right_start_time;
    logic               right_busy;

    modport source (
        output valid, left_blink_found, left_start_frame, left_start_time, left_busy,
               right_blink_found, right_start_frame, right_start_time, right_busy,
        input  ready
    );

    modport sink (
        input  valid, left_blink_found, left_start_frame, left_start_time, left_busy,
               right_blink_found, right_start_frame, right_start_time, right_busy,
        output ready
    );
endinterface

interface debd_cfg_if;
    import debd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [TIMEOUT_W-1:0] wdata;

    modport source (
        output valid, reg_index, wdata,
        input  ready
    );

    modport sink (
        input  valid, reg_index, wdata,
        output ready
    );
endinterface

@@ src/debd_lane.sv @@
// Per-eye blink detector lane: phase state, last nonzero sample and crossing record.
`timescale 1ns / 1ps

module debd_lane
    import debd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic        [FRAME_W-1:0]  frame_number,
    input  logic        [TIME_W-1:0]   time_ms,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [SAMPLE_W-1:0] low_threshold,
    input  logic signed [SAMPLE_W-1:0] high_threshold,
    input  logic        [TIMEOUT_W-1:0] arm_timeout,
    input  logic        [TIMEOUT_W-1:0] rise_timeout,
    output eye_result_t                result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_RISEN = 2'd2
    } phase_t;

    phase_t                     phase_reg;
    phase_t                     phase_next;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] prev_next;
    logic signed [SAMPLE_W-1:0] prev_eff;
    logic        [FRAME_W-1:0]  cross_frame_reg;
    logic        [FRAME_W-1:0]  cross_frame_next;
    logic        [TIME_W-1:0]   cross_time_reg;
    logic        [TIME_W-1:0]   cross_time_next;
    logic                       adding_reg;
    logic                       adding_next;
    logic        [TIME_W-1:0]   elapsed;
    logic                       found;
    logic        [FRAME_W-1:0]  start_frame;
    logic        [TIME_W-1:0]   start_time;

    always_comb
    begin
        elapsed          = time_ms - cross_time_reg;
        phase_next       = phase_reg;
        cross_frame_next = cross_frame_reg;
        cross_time_next  = cross_time_reg;
        adding_next      = adding_reg;
        found            = 1'b0;
        start_frame      = '0;
        start_time       = '0;
        prev_eff         = prev_reg;

        unique case (phase_reg)
            PH_ARMED:
            begin
                if (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, arm_timeout})
                begin
                    phase_next = PH_IDLE;
                end
                else if (sample > high_threshold)
                begin
                    phase_next = PH_RISEN;
                end
            end
            PH_RISEN:
            begin
                if (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, rise_timeout})
                begin
                    phase_next = PH_IDLE;
                end
                else if (prev_reg > 16'sd0 && sample < 16'sd0)
                begin
                    found            = 1'b1;
                    start_frame      = cross_frame_reg;
                    start_time       = cross_time_reg;
                    cross_frame_next = frame_number;
                    cross_time_next  = time_ms;
                    adding_next      = 1'b0;
                    phase_next       = PH_IDLE;
                end
            end
            default:
            begin
                if (prev_reg == 16'sd0 && sample != 16'sd0)
                begin
                    prev_eff = sample;
                end
                if (prev_eff > 16'sd0 && sample < 16'sd0)
                begin
                    cross_frame_next = frame_number;
                    cross_time_next  = time_ms;
                end
                if (sample < low_threshold)
                begin
                    adding_next = 1'b1;
                    phase_next  = PH_ARMED;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase

        prev_next = (sample != 16'sd0) ? sample : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            prev_reg        <= '0;
            cross_frame_reg <= '0;
            cross_time_reg  <= '0;
            adding_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            prev_reg        <= prev_next;
            cross_frame_reg <= cross_frame_next;
            cross_time_reg  <= cross_time_next;
            adding_reg      <= adding_next;
        end
    end

    assign result.found       = found;
    assign result.start_frame = start_frame;
    assign result.start_time  = start_time;
    assign result.busy        = adding_next;

endmodule

@@ src/debd_merge.sv @@
// Merge stage: joins both lane results into one transaction behind a skid buffer.
`timescale 1ns / 1ps

module debd_merge
    import debd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  eye_result_t  left,
    input  eye_result_t  right,
    output logic         push_ready,
    debd_blink_if.source blinks
);

    blink_item_t push_item;
    blink_item_t main_reg;
    blink_item_t skid_reg;
    logic        main_valid_reg;
    logic        skid_valid_reg;
    logic        pop;

    assign push_item.left  = left;
    assign push_item.right = right;
    assign push_ready      = !skid_valid_reg;
    assign pop             = main_valid_reg && blinks.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (pop)
            begin
                main_valid_reg <= push;
            end
            else if (push && !main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // hold payload: pop moves skid to main; push fills main when free, else skid
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_item;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_reg <= push_item;
        end
    end

    assign blinks.valid             = main_valid_reg;
    assign blinks.left_blink_found  = main_reg.left.found;
    assign blinks.left_start_frame  = main_reg.left.start_frame;
    assign blinks.left_start_time   = main_reg.left.start_time;
    assign blinks.left_busy         = main_reg.left.busy;
    assign blinks.right_blink_found = main_reg.right.found;
    assign blinks.right_start_frame = main_reg.right.start_frame;
    assign blinks.right_start_time  = main_reg.right.start_time;
    assign blinks.right_busy        = main_reg.right.busy;

endmodule

@@ src/dual_eye_blink_detector.sv @@
// Top level: dual eye blink detector with two lanes, merge stage and timeout registers.
//
//  channel  | modport | carries
//  ---------+---------+----------------------------------------------------
//  frames   | sink    | frame number, timestamp, per-eye sample and thresholds
//  blinks   | source  | per-eye blink flag, start frame, start time, busy flag
//  cfg      | sink    | timeout register index and write data
//
//  One frame per cycle while frames.ready is high; each result is registered.
//  Both lanes update their state in the accepting cycle; the merge stage's
//  two-entry skid buffer keeps frames.ready high while blinks stalls for one item.
//  frames.ready drops only when both buffer entries are full.
//  Reset clears lane state and loads the timeouts with 500 ms and 800 ms.
`timescale 1ns / 1ps

module dual_eye_blink_detector
    import debd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    debd_frame_if.sink   frames,
    debd_blink_if.source blinks,
    debd_cfg_if.sink     cfg
);

    logic [TIMEOUT_W-1:0] arm_timeout_reg;
    logic [TIMEOUT_W-1:0] rise_timeout_reg;
    logic                 accept;
    logic                 push_ready;
    eye_result_t          left_result;
    eye_result_t          right_result;

    assign cfg.ready    = 1'b1;
    assign frames.ready = push_ready;
    assign accept       = frames.valid && push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_timeout_reg  <= ARM_TIMEOUT_RESET;
            rise_timeout_reg <= RISE_TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.reg_index))
                REG_ARM_TIMEOUT:  arm_timeout_reg  <= cfg.wdata;
                REG_RISE_TIMEOUT: rise_timeout_reg <= cfg.wdata;
                default:          arm_timeout_reg  <= arm_timeout_reg;
            endcase
        end
    end

    debd_lane u_left_lane (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .frame_number   (frames.frame_number),
        .time_ms        (frames.time_ms),
        .sample         (frames.left_sample),
        .low_threshold  (frames.left_low_threshold),
        .high_threshold (frames.left_high_threshold),
        .arm_timeout    (arm_timeout_reg),
        .rise_timeout   (rise_timeout_reg),
        .result         (left_result)
    );

    debd_lane u_right_lane (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .frame_number   (frames.frame_number),
        .time_ms        (frames.time_ms),
        .sample         (frames.right_sample),
        .low_threshold  (frames.right_low_threshold),
        .high_threshold (frames.right_high_threshold),
        .arm_timeout    (arm_timeout_reg),
        .rise_timeout   (rise_timeout_reg),
        .result         (right_result)
    );

    debd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .left       (left_result),
        .right      (right_result),
        .push_ready (push_ready),
        .blinks     (blinks)
    );

endmodule

@@ bench/tb.sv @@
// Testbench for the dual eye blink detector: directed and random frames with a per-eye predictor.
`timescale 1ns / 1ps

module tb;
    import debd_pkg::*;

    localparam int LEFT_EYE    = 0;
    localparam int RIGHT_EYE   = 1;
    localparam int PHASE_ITEMS = 180;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    localparam logic [1:0] STALL_NONE   = 2'd0;
    localparam logic [1:0] STALL_COIN   = 2'd1;
    localparam logic [1:0] STALL_SPARSE = 2'd2;

    typedef enum logic [1:0] {
        EYE_IDLE  = 2'd0,
        EYE_ARMED = 2'd1,
        EYE_RISEN = 2'd2
    } eye_phase_t;

    typedef struct packed {
        eye_phase_t          phase;
        logic [SAMPLE_W-1:0] last_nonzero;
        logic [FRAME_W-1:0]  cross_frame;
        logic [TIME_W-1:0]   cross_time;
        logic                adding;
    } eye_track_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_number;
        logic [TIME_W-1:0]   time_ms;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] left_low;
        logic [SAMPLE_W-1:0] left_high;
        logic [SAMPLE_W-1:0] right_sample;
        logic [SAMPLE_W-1:0] right_low;
        logic [SAMPLE_W-1:0] right_high;
    } frame_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } eye_input_t;

    logic clk = 1'b0;
    logic rst_n;

    debd_frame_if frames ();
    debd_blink_if blinks ();
    debd_cfg_if   cfg ();

    dual_eye_blink_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frames (frames),
        .blinks (blinks),
        .cfg    (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    eye_track_t            eye_trk [2];
    logic [TIMEOUT_W-1:0]  arm_limit;
    logic [TIMEOUT_W-1:0]  rise_limit;
    frame_item_t           frame_plan [$];
    blink_item_t           pending_blinks [$];
    eye_input_t            left_plan [$];
    eye_input_t            right_plan [$];
    frame_item_t           offered;
    bit                    take_next;
    int                    burst_left;
    int                    gap_left;
    int                    mismatches;
    int                    quiet_cycles;
    logic [1:0]            stall_mode;
    logic [6:0]            stall_clock;

    function automatic eye_result_t advance_eye(input int side,
                                                input logic [FRAME_W-1:0] frame,
                                                input logic [TIME_W-1:0] now,
                                                input logic [SAMPLE_W-1:0] smp,
                                                input logic [SAMPLE_W-1:0] lo,
                                                input logic [SAMPLE_W-1:0] hi);
        eye_track_t        e;
        eye_result_t       r;
        logic [TIME_W-1:0] elapsed;
        e = eye_trk[side];
        r = '0;
        elapsed = now - e.cross_time;
        case (e.phase)
            EYE_ARMED:
            begin
                if (elapsed > 32'(arm_limit))
                    e.phase = EYE_IDLE;
                else if ($signed(smp) > $signed(hi))
                    e.phase = EYE_RISEN;
            end
            EYE_RISEN:
            begin
                if (elapsed > 32'(rise_limit))
                begin
                    e.phase = EYE_IDLE;
                end
                else if ($signed(e.last_nonzero) > 0 && $signed(smp) < 0)
                begin
                    r.found       = 1'b1;
                    r.start_frame = e.cross_frame;
                    r.start_time  = e.cross_time;
                    e.cross_frame = frame;
                    e.cross_time  = now;
                    e.adding      = 1'b0;
                    e.phase       = EYE_IDLE;
                end
            end
            default:
            begin
                if (e.last_nonzero == '0 && smp != '0)
                    e.last_nonzero = smp;
                if ($signed(e.last_nonzero) > 0 && $signed(smp) < 0)
                begin
                    e.cross_frame = frame;
                    e.cross_time  = now;
                end
                if ($signed(smp) < $signed(lo))
                begin
                    e.adding = 1'b1;
                    e.phase  = EYE_ARMED;
                end
                else
                begin
                    e.phase = EYE_IDLE;
                end
            end
        endcase
        if (smp != '0)
            e.last_nonzero = smp;
        r.busy = e.adding;
        eye_trk[side] = e;
        return r;
    endfunction

    function automatic blink_item_t predict_blinks(input frame_item_t f);
        blink_item_t b;
        b.left  = advance_eye(LEFT_EYE, f.frame_number, f.time_ms,
                              f.left_sample, f.left_low, f.left_high);
        b.right = advance_eye(RIGHT_EYE, f.frame_number, f.time_ms,
                              f.right_sample, f.right_low, f.right_high);
        return b;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d: %s expected %0h got %0h", mismatches, what, want, got);
    endtask

    task automatic check_eye(input string side, input eye_result_t want, input eye_result_t got);
        if (got.found !== want.found)
            note_mismatch({side, "_blink_found"}, 64'(want.found), 64'(got.found));
        if (got.start_frame !== want.start_frame)
            note_mismatch({side, "_start_frame"}, 64'(want.start_frame),
                          64'(got.start_frame));
        if (got.start_time !== want.start_time)
            note_mismatch({side, "_start_time"}, 64'(want.start_time),
                          64'(got.start_time));
        if (got.busy !== want.busy)
            note_mismatch({side, "_busy"}, 64'(want.busy), 64'(got.busy));
    endtask

    // drive frames in bursts, predict on every transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frames.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            take_next = !frames.valid;
            if (frames.valid && frames.ready)
            begin
                pending_blinks.insert(pending_blinks.size(), predict_blinks(offered));
                take_next = 1'b1;
            end
            if (take_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    frames.valid <= 1'b0;
                end
                else if (frame_plan.size() > 0)
                begin
                    offered = frame_plan[0];
                    frame_plan.delete(0);
                    frames.valid                <= 1'b1;
                    frames.frame_number         <= offered.frame_number;
                    frames.time_ms              <= offered.time_ms;
                    frames.left_sample          <= offered.left_sample;
                    frames.left_low_threshold   <= offered.left_low;
                    frames.left_high_threshold  <= offered.left_high;
                    frames.right_sample         <= offered.right_sample;
                    frames.right_low_threshold  <= offered.right_low;
                    frames.right_high_threshold <= offered.right_high;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    frames.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            blinks.ready <= 1'b0;
            stall_clock = '0;
            stall_mode  = STALL_NONE;
        end
        else
        begin
            if (stall_clock == '0)
                stall_mode = 2'($urandom_range(0, 3));
            stall_clock = stall_clock + 7'd1;
            case (stall_mode)
                STALL_NONE:   blinks.ready <= 1'b1;
                STALL_COIN:   blinks.ready <= 1'($urandom_range(0, 1));
                STALL_SPARSE: blinks.ready <= (stall_clock[1:0] == 2'd0);
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        blinks.ready <= !blinks.ready;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        eye_result_t got_left;
        eye_result_t got_right;
        blink_item_t want;
        if (rst_n && blinks.valid && blinks.ready)
        begin
            got_left  = {blinks.left_blink_found, blinks.left_start_frame,
                         blinks.left_start_time, blinks.left_busy};
            got_right = {blinks.right_blink_found, blinks.right_start_frame,
                         blinks.right_start_time, blinks.right_busy};
            if (pending_blinks.size() == 0)
            begin
                note_mismatch("result with no frame pending", '0,
                              64'({got_left.start_frame, got_right.start_frame}));
            end
            else
            begin
                want = pending_blinks[0];
                pending_blinks.delete(0);
                check_eye("left", want.left, got_left);
                check_eye("right", want.right, got_right);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (frames.valid && frames.ready) || (blinks.valid && blinks.ready)
            || (cfg.valid && cfg.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("dual_eye_blink_detector verification failed");
                $finish;
            end
        end
    end

    task automatic push_frame(input logic [31:0] fnum, input logic [31:0] tnow,
                              input logic [15:0] ls, input logic [15:0] ll,
                              input logic [15:0] lh, input logic [15:0] rs,
                              input logic [15:0] rl, input logic [15:0] rh);
        frame_plan.insert(frame_plan.size(),
                          frame_item_t'{fnum, tnow, ls, ll, lh, rs, rl, rh});
    endtask

    task automatic wait_drained();
        while (frame_plan.size() != 0 || frames.valid || pending_blinks.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [TIMEOUT_W-1:0] value);
        @(posedge clk);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wdata     <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == REG_ARM_TIMEOUT)
            arm_limit = value;
        else
            rise_limit = value;
    endtask

    function automatic logic [15:0] with_dropout(input logic [15:0] s);
        return ($urandom_range(0, 11) == 0) ? 16'd0 : s;
    endfunction

    task automatic add_eye_step(input int side, input logic [15:0] s,
                                input logic [15:0] lo, input logic [15:0] hi);
        if (side == LEFT_EYE)
            left_plan.insert(left_plan.size(), eye_input_t'{s, lo, hi});
        else
            right_plan.insert(right_plan.size(), eye_input_t'{s, lo, hi});
    endtask

    // noise, an arming that never rises, or a full blink
    task automatic plan_eye(input int side);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        int                 roll;
        int                 spread;
        lo     = 16'sd0 - 16'($urandom_range(1, 2048));
        hi     = 16'($urandom_range(0, 2048));
        spread = int'(hi) - int'(lo) + 500;
        roll   = $urandom_range(0, 99);
        if (roll < 15)
        begin
            repeat ($urandom_range(1, 6))
                add_eye_step(side, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                add_eye_step(side, with_dropout(16'($urandom_range(1, 6000))), lo, hi);
            add_eye_step(side, lo - 16'($urandom_range(1, 2000)), lo, hi);
            repeat ($urandom_range(0, 3))
                add_eye_step(side, with_dropout(hi - 16'($urandom_range(0, spread))), lo, hi);
            if (roll < 40)
            begin
                repeat ($urandom_range(1, 4))
                    add_eye_step(side, with_dropout(hi - 16'($urandom_range(0, spread))),
                                 lo, hi);
            end
            else
            begin
                add_eye_step(side, hi + 16'($urandom_range(1, 4000)), lo, hi);
                repeat ($urandom_range(0, 3))
                    add_eye_step(side, with_dropout(16'($urandom_range(1, 6000))), lo, hi);
                add_eye_step(side, 16'sd0 - 16'($urandom_range(1, 3000)), lo, hi);
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] arm, input logic [15:0] rise,
                             input int step_max, input logic [31:0] t0, input int count);
        logic [31:0] fnum;
        logic [31:0] tnow;
        eye_input_t  l;
        eye_input_t  r;
        int          roll;
        write_reg(REG_ARM_TIMEOUT, arm);
        write_reg(REG_RISE_TIMEOUT, rise);
        @(negedge clk);
        fnum = $urandom;
        tnow = t0;
        repeat (count)
        begin
            if (left_plan.size() == 0)
                plan_eye(LEFT_EYE);
            if (right_plan.size() == 0)
                plan_eye(RIGHT_EYE);
            l = left_plan[0];
            left_plan.delete(0);
            r = right_plan[0];
            right_plan.delete(0);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                tnow = tnow - $urandom_range(1, 1000);
            else if (roll < 4)
                tnow = tnow + $urandom_range(0, 100000);
            else
                tnow = tnow + $urandom_range(0, step_max);
            fnum = ($urandom_range(0, 49) == 0) ? $urandom : fnum + 1;
            frame_plan.insert(frame_plan.size(),
                              frame_item_t'{fnum, tnow, l.sample, l.low, l.high,
                                            r.sample, r.low, r.high});
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n                       = 1'b0;
        frames.valid                = 1'b0;
        frames.frame_number         = '0;
        frames.time_ms              = '0;
        frames.left_sample          = '0;
        frames.left_low_threshold   = '0;
        frames.left_high_threshold  = '0;
        frames.right_sample         = '0;
        frames.right_low_threshold  = '0;
        frames.right_high_threshold = '0;
        blinks.ready                = 1'b0;
        cfg.valid                   = 1'b0;
        cfg.reg_index               = REG_ARM_TIMEOUT;
        cfg.wdata                   = '0;
        mismatches                  = 0;
        quiet_cycles                = 0;
        arm_limit                   = ARM_TIMEOUT_RESET;
        rise_limit                  = RISE_TIMEOUT_RESET;
        eye_trk[LEFT_EYE]           = '0;
        eye_trk[RIGHT_EYE]          = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // wrap of the timestamp, zero samples, blinks on both eyes
        push_frame(32'h0000_0000, 32'hFFFF_FF00, 16'h0100, 16'hFF00, 16'h0100,
                   16'h0000, 16'h8000, 16'h7FFF);
        push_frame(32'h0000_0001, 32'hFFFF_FF10, 16'hFE00, 16'hFF00, 16'h0100,
                   16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_frame(32'h0000_0002, 32'hFFFF_FF80, 16'h0101, 16'hFF00, 16'h0100,
                   16'h8000, 16'h7FFF, 16'h7FFF);
        push_frame(32'h0000_0003, 32'h0000_0010, 16'h0000, 16'hFF00, 16'h0100,
                   16'h7FFF, 16'h7FFF, 16'h7FFE);
        push_frame(32'h0000_0004, 32'h0000_0020, 16'hFFFF, 16'hFF00, 16'h0100,
                   16'h8000, 16'h7FFF, 16'h7FFE);
        // thresholds met exactly, arm timeout at its boundary and one past
        push_frame(32'h0000_0005, 32'h0000_0030, 16'h0100, 16'hFF00, 16'h0100,
                   16'h0100, 16'h8000, 16'h7FFF);
        push_frame(32'h0000_0006, 32'h0000_0040, 16'hFF00, 16'hFF00, 16'h0100,
                   16'hFD00, 16'hFF00, 16'h0100);
        push_frame(32'h0000_0007, 32'h0000_0234, 16'hFE00, 16'hFF00, 16'h0100,
                   16'h0100, 16'hFF00, 16'h0100);
        push_frame(32'h0000_0008, 32'h0000_0235, 16'h7FFF, 16'hFF00, 16'h0100,
                   16'h7FFF, 16'hFF00, 16'h0100);
        // timestamp going backwards
        push_frame(32'h0000_0009, 32'h0000_0240, 16'hFE00, 16'hFF00, 16'h0100,
                   16'hFE00, 16'hFF00, 16'h0100);
        push_frame(32'h0000_000A, 32'h0000_023F, 16'h7FFF, 16'hFF00, 16'h0100,
                   16'h7FFF, 16'hFF00, 16'h0100);
        // rise at the arm boundary, blink at the rise boundary, rise timeout one past it
        push_frame(32'h0000_000B, 32'h0000_0300, 16'h0100, 16'hFF00, 16'h0100,
                   16'h0200, 16'hFF00, 16'h0100);
        push_frame(32'h0000_000C, 32'h0000_0310, 16'hFE00, 16'hFF00, 16'h0100,
                   16'hFE00, 16'hFF00, 16'h0100);
        push_frame(32'h0000_000D, 32'h0000_0504, 16'h0101, 16'hFF00, 16'h0100,
                   16'h0101, 16'hFF00, 16'h0100);
        push_frame(32'h0000_000E, 32'h0000_0630, 16'h8000, 16'hFF00, 16'h0100,
                   16'h0200, 16'hFF00, 16'h0100);
        push_frame(32'h0000_000F, 32'h0000_0631, 16'h0100, 16'hFF00, 16'h0100,
                   16'hFF00, 16'hFF00, 16'h0100);
        // extreme samples and thresholds, extreme frame numbers
        push_frame(32'hFFFF_FFFF, 32'h0000_0640, 16'h8000, 16'h8000, 16'h7FFF,
                   16'h7FFF, 16'h7FFF, 16'h8000);
        push_frame(32'h5555_AAAA, 32'h0000_0650, 16'h7FFF, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h7FFF, 16'h8000);
        push_frame(32'hAAAA_5555, 32'h0000_0660, 16'h8000, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h7FFF, 16'h8000);
        push_frame(32'h1234_5678, 32'h0000_0670, 16'h7FFF, 16'h7FFF, 16'h8000,
                   16'h7FFF, 16'h7FFF, 16'h8000);
        push_frame(32'h9ABC_DEF0, 32'h0000_0680, 16'h8000, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h7FFF, 16'h8000);
        wait_drained();

        run_phase(16'd300, 16'd700, 40, $urandom, PHASE_ITEMS);
        run_phase(16'd0, 16'd0, 0, 32'hFFFF_F000, PHASE_ITEMS);
        run_phase(16'hFFFF, 16'hFFFF, 3000, $urandom, PHASE_ITEMS);
        run_phase(16'($urandom), 16'($urandom), 200, $urandom, PHASE_ITEMS);
        run_phase(16'd20, 16'd60, 12, $urandom, PHASE_ITEMS);
        run_phase(ARM_TIMEOUT_RESET, RISE_TIMEOUT_RESET, 60, $urandom, PHASE_ITEMS);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("dual_eye_blink_detector verification clean");
        else
            $display("dual_eye_blink_detector verification failed");
        $finish;
    end

endmodule
